[rtl/mpe_pkg.sv]
// Shared types, constants and character class helpers for the mask password enumerator.
package mpe_pkg;

    // Sizes fixed by the field widths
    localparam int MAX_POSITIONS_DEF = 5;
    localparam int NUM_OUT_CHARS     = 5;
    localparam int NUM_CLASS_POS     = 5;
    localparam int CLS_W             = 3;
    localparam int DIGIT_W           = 5;
    localparam int CHAR_W            = 7;
    localparam int LEN_W             = 3;
    localparam int COUNT_W           = 26;
    localparam int CFG_W             = 15;
    localparam int CFG_IDX_W         = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_CLASSES = 2'd1;

    // Character class codes
    localparam logic [CLS_W-1:0] CLS_UPPER  = 3'd0;
    localparam logic [CLS_W-1:0] CLS_LOWER  = 3'd1;
    localparam logic [CLS_W-1:0] CLS_DIGIT  = 3'd2;
    localparam logic [CLS_W-1:0] CLS_SYMBOL = 3'd3;

    // Signals handed from one cell to its more significant neighbor
    typedef struct packed {
        logic carry;   // increment reaches this position
        logic last;    // every less significant used position sits at its top
        logic ok;      // every less significant used position has a valid class
    } t_link;

    // Per-transaction control broadcast to all cells
    typedef struct packed {
        logic restart; // current request starts over
        logic accept;  // request accepted this cycle
        logic fire;    // request yields a candidate
    } t_ctrl;

    // True for the four defined classes
    function automatic logic class_valid(input logic [CLS_W-1:0] cls);
        case (cls) inside
            CLS_UPPER, CLS_LOWER, CLS_DIGIT, CLS_SYMBOL: class_valid = 1'b1;
            default:                                     class_valid = 1'b0;
        endcase
    endfunction

    // Index of the last member of a class
    function automatic logic [DIGIT_W-1:0] class_top(input logic [CLS_W-1:0] cls);
        case (cls)
            CLS_UPPER: class_top = 5'd25;
            CLS_LOWER: class_top = 5'd25;
            CLS_DIGIT: class_top = 5'd9;
            default:   class_top = 5'd31;
        endcase
    endfunction

    // ASCII code of member d of a class; symbols come in four runs
    function automatic logic [CHAR_W-1:0] class_char(input logic [CLS_W-1:0]   cls,
                                                     input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        dw = {2'b00, d};
        case (cls)
            CLS_UPPER: class_char = dw + 7'd65;
            CLS_LOWER: class_char = dw + 7'd97;
            CLS_DIGIT: class_char = dw + 7'd48;
            default: begin
                if (d < 5'd15)      class_char = dw + 7'd33;
                else if (d < 5'd22) class_char = dw + 7'd43;
                else if (d < 5'd28) class_char = dw + 7'd69;
                else                class_char = dw + 7'd95;
            end
        endcase
    endfunction

endpackage

[rtl/mask_password_enumerator.sv]
// Top level of the mask password enumerator: config, cell chain, count and output register.
// Each accepted request (restart 1 starts over, 0 advances) yields at most one candidate:
// the string that fits the configured mask (mask_length positions, 3-bit class each, position 0
// most significant), a last flag and the count since the last restart. One request is taken
// every cycle while the output register is empty or being drained; the output register fills
// in the cycle after acceptance. The odometer carry ripples combinationally through the row of
// MAX_POSITIONS cells, so its length sets the clock period. A request after the last candidate
// or with an invalid class in a used position is consumed without a result. Write the
// configuration only while no transaction is pending.
module mask_password_enumerator
    import mpe_pkg::*;
#(
    parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart,
    // candidate channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [CHAR_W-1:0]    o_char_0,
    output logic [CHAR_W-1:0]    o_char_1,
    output logic [CHAR_W-1:0]    o_char_2,
    output logic [CHAR_W-1:0]    o_char_3,
    output logic [CHAR_W-1:0]    o_char_4,
    output logic                 o_final_candidate,
    output logic [COUNT_W-1:0]   o_emitted_count
);

    logic [LEN_W-1:0]   r_mask_length;
    logic [CFG_W-1:0]   r_mask_classes;
    logic               r_exhausted;
    logic [COUNT_W-1:0] r_total;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_char [NUM_OUT_CHARS];
    logic               r_final;
    logic [COUNT_W-1:0] r_count;

    logic               w_accept;
    logic               w_ex_eff;
    logic               w_fire;
    logic [COUNT_W-1:0] w_total_eff;
    logic [COUNT_W-1:0] n_total;
    t_ctrl              w_ctrl;
    t_link              w_link [MAX_POSITIONS+1];
    logic               w_active [MAX_POSITIONS];
    logic [CLS_W-1:0]   w_class [MAX_POSITIONS];
    logic [CHAR_W-1:0]  w_cell_char [MAX_POSITIONS];
    logic [CHAR_W-1:0]  w_char [NUM_OUT_CHARS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_length  <= '0;
            r_mask_classes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MASK_LENGTH:  r_mask_length  <= i_cfg_data[LEN_W-1:0];
                CFG_MASK_CLASSES: r_mask_classes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake and step decision
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_ex_eff       = i_restart ? 1'b0 : r_exhausted;
        w_total_eff    = i_restart ? '0 : r_total;
        w_fire         = w_accept && !w_ex_eff && w_link[0].ok;
        n_total        = (w_total_eff == COUNT_MAX) ? w_total_eff : w_total_eff + 1'b1;
        w_ctrl.restart = i_restart;
        w_ctrl.accept  = w_accept;
        w_ctrl.fire    = w_fire;
    end

    // Row of cells; the least significant end starts the chain
    assign w_link[MAX_POSITIONS] = '{carry: 1'b1, last: 1'b1, ok: 1'b1};

    for (genvar g = 0; g < MAX_POSITIONS; g++) begin : g_cell
        assign w_active[g] = (32'(g) < 32'(r_mask_length));
        if (g < NUM_CLASS_POS) begin : g_cls
            assign w_class[g] = r_mask_classes[CLS_W*g +: CLS_W];
        end else begin : g_cls_fixed
            assign w_class[g] = CLS_UPPER;
        end

        mpe_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_active (w_active[g]),
            .i_class  (w_class[g]),
            .i_ctrl   (w_ctrl),
            .i_link   (w_link[g+1]),
            .o_link   (w_link[g]),
            .o_char   (w_cell_char[g])
        );
    end

    for (genvar k = 0; k < NUM_OUT_CHARS; k++) begin : g_char
        if (k < MAX_POSITIONS) begin : g_used
            assign w_char[k] = w_cell_char[k];
        end else begin : g_unused
            assign w_char[k] = '0;
        end
    end

    // Enumeration status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exhausted <= 1'b0;
            r_total     <= '0;
        end else if (w_accept) begin
            r_exhausted <= w_fire ? w_link[0].last : w_ex_eff;
            r_total     <= w_fire ? n_total : w_total_eff;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_char  <= w_char;
            r_final <= w_link[0].last;
            r_count <= n_total;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_char_0          = r_char[0];
    assign o_char_1          = r_char[1];
    assign o_char_2          = r_char[2];
    assign o_char_3          = r_char[3];
    assign o_char_4          = r_char[4];
    assign o_final_candidate = r_final;
    assign o_emitted_count   = r_count;

endmodule

[rtl/mpe_cell.sv]
// One odometer position: digit register, clamp, character lookup and carry.
module mpe_cell
    import mpe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_active,
    input  logic [CLS_W-1:0]   i_class,
    input  t_ctrl              i_ctrl,
    input  t_link              i_link,
    output t_link              o_link,
    output logic [CHAR_W-1:0]  o_char
);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_eff;
    logic [DIGIT_W-1:0] w_top;
    logic [DIGIT_W-1:0] w_clamped;
    logic [DIGIT_W-1:0] w_adv;
    logic               w_at_top;

    // Digit as seen by this request, clamped into the class
    always_comb begin
        w_eff     = i_ctrl.restart ? '0 : r_digit;
        w_top     = class_top(i_class);
        w_clamped = (w_eff > w_top) ? w_top : w_eff;
        w_at_top  = (w_clamped == w_top);
    end

    // Advance and pass link signals on; unused positions pass straight through
    always_comb begin
        if (i_active) begin
            w_adv        = i_link.carry ? (w_at_top ? '0 : w_clamped + 1'b1) : w_clamped;
            o_link.carry = i_link.carry & w_at_top;
            o_link.last  = i_link.last & w_at_top;
            o_link.ok    = i_link.ok & class_valid(i_class);
            o_char       = class_char(i_class, w_clamped);
        end else begin
            w_adv  = w_eff;
            o_link = i_link;
            o_char = '0;
        end
        n_digit = i_ctrl.fire ? w_adv : w_eff;
    end

    // Digit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else if (i_ctrl.accept) begin
            r_digit <= n_digit;
        end
    end

endmodule

[rtl/mpe_checker.sv]
// Port-level checks for the mask password enumerator and their bind.
module mpe_checker
    import mpe_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [COUNT_W-1:0] o_emitted_count
);

    // No candidate is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled candidate stays with its count
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_emitted_count))
        else $error("stalled candidate changed");

    // Every candidate counts itself
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_emitted_count != '0)
        else $error("candidate with zero count");

    // Requests are blocked only by a full, stalled output
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request stalled without cause");

endmodule

bind mask_password_enumerator mpe_checker u_mpe_checker (.*);
